// ===== design/tfd_pkg.sv =====
// Shared types and constants for the threshold fault debounce block.
package tfd_pkg;

  // Input item actions.
  typedef enum logic [1:0] {
    ACT_BOOL   = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_CONTROL     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TRIP        = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RECOVER     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RISE_STEP   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_FALL_STEP   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_COUNT_LIMIT = 3'd5;

  // Step widths and reset values.
  localparam int unsigned STEP_BITS   = 8;
  localparam int unsigned CTRL_BITS   = 4;
  localparam int unsigned LIMIT_RESET = 10;
  localparam int unsigned STEP_RESET  = 1;

  // Control flags, bit 3 down to bit 0.
  typedef struct packed {
    logic masked;
    logic unmasked_only;
    logic recoverable;
    logic under_trips;
  } ctrl_t;

  // Fault flags held with the counter.
  typedef struct packed {
    logic raw;
    logic reported;
  } fault_t;

endpackage

// ===== design/tfd_channels.sv =====
// Handshake channel interfaces for the input, result and configuration items.
interface tfd_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic                          exceeded;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source(output valid, action, exceeded, sample, input ready);
  modport sink(input valid, action, exceeded, sample, output ready);
endinterface

interface tfd_out_if #(
  parameter int unsigned COUNT_BITS = 16
) ();
  logic                  valid;
  logic                  ready;
  logic                  fault_reported;
  logic                  fault_raw;
  logic [COUNT_BITS-1:0] count_now;

  modport source(output valid, fault_reported, fault_raw, count_now, input ready);
  modport sink(input valid, fault_reported, fault_raw, count_now, output ready);
endinterface

interface tfd_cfg_if #(
  parameter int unsigned DATA_BITS = 16
) ();
  logic                              valid;
  logic                              ready;
  logic [tfd_pkg::CFG_IDX_BITS-1:0]  index;
  logic [DATA_BITS-1:0]              data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== design/tfd_update.sv =====
// Next-state logic of the debounce counter and fault flags for one item.
module tfd_update #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic [1:0]                         action_i,
  input  logic                               exceeded_i,
  input  logic signed [SAMPLE_BITS-1:0]      sample_i,
  input  tfd_pkg::ctrl_t                     ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0]      trip_i,
  input  logic signed [SAMPLE_BITS-1:0]      recover_i,
  input  logic [tfd_pkg::STEP_BITS-1:0]      rise_step_i,
  input  logic [tfd_pkg::STEP_BITS-1:0]      fall_step_i,
  input  logic [COUNT_BITS-1:0]              limit_i,
  input  logic [COUNT_BITS-1:0]              count_i,
  input  tfd_pkg::fault_t                    fault_i,
  output logic [COUNT_BITS-1:0]              count_o,
  output tfd_pkg::fault_t                    fault_o
);

  // Working width holds the counter plus a step either way, with a sign bit.
  localparam int unsigned BASE_BITS =
      (COUNT_BITS > tfd_pkg::STEP_BITS) ? COUNT_BITS : tfd_pkg::STEP_BITS;
  localparam int unsigned W = BASE_BITS + 2;

  logic signed [W-1:0] cnt_ext;
  logic signed [W-1:0] cnt_up;
  logic signed [W-1:0] cnt_dn;
  logic signed [W-1:0] lim_ext;
  logic                frozen;

  assign cnt_ext = W'(count_i);
  assign lim_ext = W'(limit_i);
  assign cnt_up  = cnt_ext + W'(rise_step_i);
  assign cnt_dn  = cnt_ext - W'(fall_step_i);
  assign frozen  = ctrl_i.unmasked_only & ctrl_i.masked;

  // Pick the moved counter, then apply the saturation tests the action calls for.
  always_comb begin
    logic signed [W-1:0] c;
    logic                go_up;
    logic                go_dn;
    logic                test_up;
    logic                test_lo;
    c       = cnt_ext;
    go_up   = 1'b0;
    go_dn   = 1'b0;
    test_up = 1'b0;
    test_lo = 1'b0;
    fault_o = fault_i;

    case (action_i)
      tfd_pkg::ACT_BOOL: begin
        if (!frozen) begin
          if (exceeded_i) begin
            go_up   = 1'b1;
            test_up = 1'b1;
          end else if (ctrl_i.recoverable) begin
            go_dn   = 1'b1;
            test_lo = 1'b1;
          end
        end
      end
      tfd_pkg::ACT_SAMPLE: begin
        if (!frozen) begin
          if (ctrl_i.under_trips) begin
            go_up = (sample_i < trip_i);
            go_dn = !go_up && (sample_i > recover_i) && ctrl_i.recoverable;
          end else begin
            go_up = (sample_i > trip_i);
            go_dn = !go_up && (sample_i < recover_i) && ctrl_i.recoverable;
          end
          test_up = 1'b1;
          test_lo = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (go_up) begin
      c = cnt_up;
    end else if (go_dn) begin
      c = cnt_dn;
    end

    // The upper bound has priority; the lower bound is tested only if it missed.
    // At or below zero means negative (sign bit set) or exactly zero.
    if (test_up && (c >= lim_ext)) begin
      c                = lim_ext;
      fault_o.raw      = 1'b1;
      fault_o.reported = !ctrl_i.masked;
    end else if (test_lo && (c[W-1] || (c == '0))) begin
      c       = '0;
      fault_o = '0;
    end

    // A clear overrides everything, mask or not.
    if (action_i == tfd_pkg::ACT_CLEAR) begin
      c       = '0;
      fault_o = '0;
    end

    count_o = c[COUNT_BITS-1:0];
  end

endmodule

// ===== design/threshold_fault_debounce.sv =====
// Top level of the threshold fault debounce block: registers, handshake and configuration.
// An accepted item is registered in the input register, then its result in the state
// registers once they are free. Throughput: one item per cycle while results are taken,
// set by the single add and clamp on the counter.
// Reset clears the counter, both fault flags and the channel valids, and restores the
// configuration defaults (flags 0, thresholds 0, steps 1, count limit 10).
module threshold_fault_debounce #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tfd_in_if.sink     in_ch_i,
  tfd_out_if.source  out_ch_o,
  tfd_cfg_if.sink    cfg_i
);

  logic [tfd_pkg::CTRL_BITS-1:0]  ctrl_q;
  logic signed [SAMPLE_BITS-1:0]  trip_q;
  logic signed [SAMPLE_BITS-1:0]  recover_q;
  logic [tfd_pkg::STEP_BITS-1:0]  rise_step_q;
  logic [tfd_pkg::STEP_BITS-1:0]  fall_step_q;
  logic [COUNT_BITS-1:0]          limit_q;

  logic                           in_valid_q;
  logic [1:0]                     action_q;
  logic                           exceeded_q;
  logic signed [SAMPLE_BITS-1:0]  sample_q;

  logic                           out_valid_q;
  logic [COUNT_BITS-1:0]          count_q;
  logic [COUNT_BITS-1:0]          count_d;
  tfd_pkg::fault_t                fault_q;
  tfd_pkg::fault_t                fault_d;

  logic                           out_free;
  logic                           step_en;
  logic                           in_fire;

  // Configuration writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= '0;
      trip_q      <= '0;
      recover_q   <= '0;
      rise_step_q <= tfd_pkg::STEP_BITS'(tfd_pkg::STEP_RESET);
      fall_step_q <= tfd_pkg::STEP_BITS'(tfd_pkg::STEP_RESET);
      limit_q     <= COUNT_BITS'(tfd_pkg::LIMIT_RESET);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        tfd_pkg::REG_CONTROL:     ctrl_q      <= cfg_i.data[tfd_pkg::CTRL_BITS-1:0];
        tfd_pkg::REG_TRIP:        trip_q      <= cfg_i.data[SAMPLE_BITS-1:0];
        tfd_pkg::REG_RECOVER:     recover_q   <= cfg_i.data[SAMPLE_BITS-1:0];
        tfd_pkg::REG_RISE_STEP:   rise_step_q <= cfg_i.data[tfd_pkg::STEP_BITS-1:0];
        tfd_pkg::REG_FALL_STEP:   fall_step_q <= cfg_i.data[tfd_pkg::STEP_BITS-1:0];
        tfd_pkg::REG_COUNT_LIMIT: limit_q     <= cfg_i.data[COUNT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Handshake: the result register frees when empty or taken, and the input
  // register moves on into it whenever it is free.
  assign out_free      = !out_valid_q || out_ch_o.ready;
  assign step_en       = in_valid_q && out_free;
  assign in_ch_i.ready = !in_valid_q || out_free;
  assign in_fire       = in_ch_i.valid && in_ch_i.ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch_i.ready) begin
      in_valid_q <= in_ch_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      action_q   <= in_ch_i.action;
      exceeded_q <= in_ch_i.exceeded;
      sample_q   <= in_ch_i.sample;
    end
  end

  // Counter update for the registered item.
  tfd_update #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_update (
    .action_i   (action_q),
    .exceeded_i (exceeded_q),
    .sample_i   (sample_q),
    .ctrl_i     (tfd_pkg::ctrl_t'(ctrl_q)),
    .trip_i     (trip_q),
    .recover_i  (recover_q),
    .rise_step_i(rise_step_q),
    .fall_step_i(fall_step_q),
    .limit_i    (limit_q),
    .count_i    (count_q),
    .fault_i    (fault_q),
    .count_o    (count_d),
    .fault_o    (fault_d)
  );

  // The state registers double as the result register: they hold the state
  // after the last step, which is exactly the result item offered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
      fault_q     <= '0;
    end else begin
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (step_en) begin
        count_q <= count_d;
        fault_q <= fault_d;
      end
    end
  end

  assign out_ch_o.valid          = out_valid_q;
  assign out_ch_o.fault_reported = fault_q.reported;
  assign out_ch_o.fault_raw      = fault_q.raw;
  assign out_ch_o.count_now      = count_q;

endmodule

// ===== test/tb_threshold_fault_debounce.sv =====
// Self-checking testbench for the threshold fault debounce block.
`timescale 1ns / 100ps

module tb_threshold_fault_debounce;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned COUNT_W     = 16;
  localparam int          RANDOM_ITEMS = 900;
  localparam int          CYCLE_LIMIT  = 200000;

  // One predicted result item: the fault flags and the counter after the step.
  typedef struct packed {
    logic               reported;
    logic               raw;
    logic [COUNT_W-1:0] count;
  } fault_status_t;

  // Tracks the debounce state and the registers, and holds the expected results in order.
  class debounce_scoreboard;
    tfd_pkg::ctrl_t             ctrl;
    logic signed [SAMPLE_W-1:0] trip_level;
    logic signed [SAMPLE_W-1:0] recover_level;
    int                         rise;
    int                         fall;
    int                         limit;
    int                         count;
    logic                       raw;
    logic                       reported;
    fault_status_t              expected_q[$];
    int                         errors;
    int                         checked;
    int                         saturations;
    int                         zero_hits;

    function new();
      ctrl          = '0;
      trip_level    = '0;
      recover_level = '0;
      rise          = int'(tfd_pkg::STEP_RESET);
      fall          = int'(tfd_pkg::STEP_RESET);
      limit         = int'(tfd_pkg::LIMIT_RESET);
      count         = 0;
      raw           = 1'b0;
      reported      = 1'b0;
      errors        = 0;
      checked       = 0;
      saturations   = 0;
      zero_hits     = 0;
    endfunction

    function void write_register(logic [tfd_pkg::CFG_IDX_BITS-1:0] idx, logic [15:0] value);
      case (idx)
        tfd_pkg::REG_CONTROL:     ctrl = tfd_pkg::ctrl_t'(value[tfd_pkg::CTRL_BITS-1:0]);
        tfd_pkg::REG_TRIP:        trip_level = value;
        tfd_pkg::REG_RECOVER:     recover_level = value;
        tfd_pkg::REG_RISE_STEP:   rise = int'(value[tfd_pkg::STEP_BITS-1:0]);
        tfd_pkg::REG_FALL_STEP:   fall = int'(value[tfd_pkg::STEP_BITS-1:0]);
        tfd_pkg::REG_COUNT_LIMIT: limit = int'(value);
        default: ;
      endcase
    endfunction

    // Saturate at the limit and set the fault; the reported flag follows the mask.
    function bit clamp_high(inout int c);
      if (c >= limit) begin
        c        = limit;
        raw      = 1'b1;
        reported = !ctrl.masked;
        saturations++;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Hold at zero and clear both fault flags.
    function void clamp_low(inout int c);
      if (c <= 0) begin
        c        = 0;
        raw      = 1'b0;
        reported = 1'b0;
        zero_hits++;
      end
    endfunction

    // Advance the state by one accepted item and queue the result it should give.
    function void note_input(tfd_pkg::action_e act, logic exc,
                             logic signed [SAMPLE_W-1:0] smp);
      bit frozen;
      bit rising;
      bit falling;
      int c;
      frozen = ctrl.unmasked_only && ctrl.masked;
      c      = count;
      case (act)
        tfd_pkg::ACT_CLEAR: begin
          c        = 0;
          raw      = 1'b0;
          reported = 1'b0;
        end
        tfd_pkg::ACT_BOOL: begin
          if (!frozen) begin
            if (exc) begin
              c += rise;
              void'(clamp_high(c));
            end else if (ctrl.recoverable) begin
              c -= fall;
              clamp_low(c);
            end
          end
        end
        tfd_pkg::ACT_SAMPLE: begin
          if (!frozen) begin
            if (ctrl.under_trips) begin
              rising  = smp < trip_level;
              falling = smp > recover_level;
            end else begin
              rising  = smp > trip_level;
              falling = smp < recover_level;
            end
            if (rising) begin
              c += rise;
            end else if (falling && ctrl.recoverable) begin
              c -= fall;
            end
            // Both bounds are tested after a sample, moved or not.
            if (!clamp_high(c)) clamp_low(c);
          end
        end
        default: ;
      endcase
      count = c & 'hFFFF;
      expected_q.push_back(fault_status_t'{reported, raw, count[COUNT_W-1:0]});
    endfunction

    task report(string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      errors++;
    endtask

    task check_result(logic rep, logic raw_seen, logic [COUNT_W-1:0] cnt);
      fault_status_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected (rep %b raw %b count %0d)",
                         rep, raw_seen, cnt));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (rep !== want.reported)
        report($sformatf("fault_reported %b, expected %b", rep, want.reported));
      if (raw_seen !== want.raw)
        report($sformatf("fault_raw %b, expected %b", raw_seen, want.raw));
      if (cnt !== want.count)
        report($sformatf("count_now %0d, expected %0d", cnt, want.count));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  int   items_sent;
  int   cfg_writes;
  int   settings_used;
  int   rx_hold;
  int   cycles;

  debounce_scoreboard sb;

  tfd_in_if  #(.SAMPLE_BITS(SAMPLE_W)) in_ch ();
  tfd_out_if #(.COUNT_BITS(COUNT_W))   out_ch ();
  tfd_cfg_if #(.DATA_BITS(16))         cfg_ch ();

  threshold_fault_debounce #(
    .SAMPLE_BITS(SAMPLE_W),
    .COUNT_BITS (COUNT_W)
  ) uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch),
    .cfg_i    (cfg_ch)
  );

  // Clock: 2 ns high, 2 ns low.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Offer one item and hold it until the block takes it.
  task automatic drive_item(tfd_pkg::action_e act, logic exc,
                            logic signed [SAMPLE_W-1:0] smp);
    @(negedge clk_i);
    in_ch.valid    <= 1'b1;
    in_ch.action   <= act;
    in_ch.exceeded <= exc;
    in_ch.sample   <= smp;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_input(act, exc, smp);
    items_sent++;
  endtask

  // Drop valid for a gap of the given number of cycles.
  task automatic idle_sender(int n);
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic wait_idle();
    idle_sender(1);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [tfd_pkg::CFG_IDX_BITS-1:0] idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.write_register(idx, value);
    cfg_writes++;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Move a level by delta, saturating at the sample range.
  function automatic logic signed [SAMPLE_W-1:0] shift_level(logic signed [SAMPLE_W-1:0] level,
                                                              int delta);
    int v;
    v = int'(level) + delta;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[SAMPLE_W-1:0];
  endfunction

  // Result sink: random stall pattern, plus a long hold-off on request.
  initial begin : result_sink
    int mode;
    int run_left;
    out_ch.ready = 1'b0;
    mode         = 0;
    run_left     = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold--;
      end else begin
        if (run_left == 0) begin
          mode     = $urandom_range(0, 2);
          run_left = $urandom_range(4, 40);
        end
        run_left--;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Every accepted result is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.fault_reported, out_ch.fault_raw, out_ch.count_now);
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles", cycles);
    $display("Test completed with failures");
    $finish;
  end

  // Main stimulus: directed checks of the corner cases, then random phases.
  initial begin : stimulus
    int                         phase;
    int                         n;
    int                         k;
    int                         r;
    int                         delta;
    int                         burst_left;
    int                         trend_left;
    int                         directed_items;
    bit                         bursty;
    bit                         rising_trend;
    logic [15:0]                v;
    logic                       exc;
    logic signed [SAMPLE_W-1:0] smp;
    tfd_pkg::action_e           act;

    in_ch.valid    = 1'b0;
    in_ch.action   = tfd_pkg::ACT_BOOL;
    in_ch.exceeded = 1'b0;
    in_ch.sample   = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = tfd_pkg::REG_CONTROL;
    cfg_ch.data    = '0;
    rx_hold        = 0;
    items_sent     = 0;
    cfg_writes     = 0;
    settings_used  = 1;
    rst_ni         = 1'b0;
    sb             = new();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Defaults after reset: the unused action, boolean and sample rise, no recovery, a clear.
    drive_item(tfd_pkg::ACT_NONE, 1'b1, 16'sh7FFF);
    drive_item(tfd_pkg::ACT_BOOL, 1'b1, 16'sh0000);
    drive_item(tfd_pkg::ACT_BOOL, 1'b1, 16'sh0000);
    drive_item(tfd_pkg::ACT_BOOL, 1'b0, 16'sh0000);
    drive_item(tfd_pkg::ACT_SAMPLE, 1'b0, 16'sh7FFF);
    drive_item(tfd_pkg::ACT_SAMPLE, 1'b1, 16'sh8000);
    drive_item(tfd_pkg::ACT_CLEAR, 1'b1, 16'shFFFF);

    // Recoverable, small limit, coarse steps: saturate, hold on an idle sample, fall to zero.
    wait_idle();
    cfg_write(tfd_pkg::REG_CONTROL, 16'h0002);
    cfg_write(tfd_pkg::REG_COUNT_LIMIT, 16'd3);
    cfg_write(tfd_pkg::REG_RISE_STEP, 16'd2);
    cfg_write(tfd_pkg::REG_FALL_STEP, 16'd255);
    settings_used++;
    drive_item(tfd_pkg::ACT_BOOL, 1'b1, 16'sh0000);
    drive_item(tfd_pkg::ACT_BOOL, 1'b1, 16'sh0000);
    drive_item(tfd_pkg::ACT_SAMPLE, 1'b0, 16'sh0000);
    drive_item(tfd_pkg::ACT_BOOL, 1'b0, 16'sh0000);

    // Under-threshold tripping with the thresholds at the ends of the range.
    wait_idle();
    cfg_write(tfd_pkg::REG_CONTROL, 16'h0003);
    cfg_write(tfd_pkg::REG_TRIP, 16'h7FFF);
    cfg_write(tfd_pkg::REG_RECOVER, 16'h8000);
    settings_used++;
    drive_item(tfd_pkg::ACT_SAMPLE, 1'b0, 16'sh8000);
    drive_item(tfd_pkg::ACT_SAMPLE, 1'b0, 16'sh7FFF);

    // Checking frozen by the mask.
    wait_idle();
    cfg_write(tfd_pkg::REG_CONTROL, 16'h000E);
    cfg_write(tfd_pkg::REG_RISE_STEP, 16'd1);
    cfg_write(tfd_pkg::REG_FALL_STEP, 16'd1);
    cfg_write(tfd_pkg::REG_COUNT_LIMIT, 16'd2);
    settings_used++;
    drive_item(tfd_pkg::ACT_BOOL, 1'b1, 16'sh0000);
    drive_item(tfd_pkg::ACT_SAMPLE, 1'b1, 16'sh8000);

    // Masked saturation keeps the reported flag low; unmasking alone leaves it low.
    wait_idle();
    cfg_write(tfd_pkg::REG_CONTROL, 16'h000A);
    settings_used++;
    drive_item(tfd_pkg::ACT_BOOL, 1'b1, 16'sh0000);
    drive_item(tfd_pkg::ACT_BOOL, 1'b1, 16'sh0000);
    wait_idle();
    cfg_write(tfd_pkg::REG_CONTROL, 16'h0002);
    settings_used++;
    drive_item(tfd_pkg::ACT_NONE, 1'b0, 16'sh0000);
    drive_item(tfd_pkg::ACT_BOOL, 1'b1, 16'sh0000);

    // A clear goes through even while frozen.
    wait_idle();
    cfg_write(tfd_pkg::REG_CONTROL, 16'h000E);
    settings_used++;
    drive_item(tfd_pkg::ACT_CLEAR, 1'b0, 16'sh0000);

    // Lowering the limit under the counter: a falling boolean leaves it, a sample clamps it.
    wait_idle();
    cfg_write(tfd_pkg::REG_CONTROL, 16'h0000);
    cfg_write(tfd_pkg::REG_COUNT_LIMIT, 16'hFFFF);
    cfg_write(tfd_pkg::REG_RISE_STEP, 16'd255);
    cfg_write(tfd_pkg::REG_TRIP, 16'h0000);
    settings_used++;
    drive_item(tfd_pkg::ACT_BOOL, 1'b1, 16'sh0000);
    drive_item(tfd_pkg::ACT_BOOL, 1'b1, 16'sh0000);
    wait_idle();
    cfg_write(tfd_pkg::REG_COUNT_LIMIT, 16'd100);
    settings_used++;
    drive_item(tfd_pkg::ACT_BOOL, 1'b0, 16'sh0000);
    drive_item(tfd_pkg::ACT_SAMPLE, 1'b0, 16'shFFFF);

    directed_items = items_sent;
    rising_trend   = 1'b0;
    trend_left     = 0;

    // Random phases: fresh settings while idle, then a run of items that tends to
    // drive the counter up to the limit and back down to zero.
    for (phase = 0; items_sent < directed_items + RANDOM_ITEMS; phase++) begin
      wait_idle();
      v = 16'($urandom_range(0, 15));
      if (v[3] && v[2] && $urandom_range(0, 3) != 0) v[2] = 1'b0;
      if (phase == 0 || $urandom_range(0, 1)) cfg_write(tfd_pkg::REG_CONTROL, v);
      if (phase == 0 || $urandom_range(0, 1)) begin
        case ($urandom_range(0, 5))
          0: v = 16'h8000;
          1: v = 16'h7FFF;
          2: v = 16'($urandom);
          default: v = shift_level('0, $urandom_range(0, 600) - 300);
        endcase
        cfg_write(tfd_pkg::REG_TRIP, v);
      end
      if (phase == 0 || $urandom_range(0, 1)) begin
        case ($urandom_range(0, 5))
          0: v = 16'h8000;
          1: v = 16'h7FFF;
          2: v = 16'($urandom);
          default: v = shift_level('0, $urandom_range(0, 600) - 300);
        endcase
        cfg_write(tfd_pkg::REG_RECOVER, v);
      end
      if (phase == 0 || $urandom_range(0, 1)) begin
        case ($urandom_range(0, 5))
          0: v = 16'd0;
          1: v = 16'd255;
          default: v = 16'($urandom_range(1, 4));
        endcase
        cfg_write(tfd_pkg::REG_RISE_STEP, v);
      end
      if (phase == 0 || $urandom_range(0, 1)) begin
        case ($urandom_range(0, 5))
          0: v = 16'd0;
          1: v = 16'd255;
          default: v = 16'($urandom_range(1, 4));
        endcase
        cfg_write(tfd_pkg::REG_FALL_STEP, v);
      end
      if (phase == 0 || $urandom_range(0, 1)) begin
        case ($urandom_range(0, 7))
          0: v = 16'd1;
          1: v = 16'hFFFF;
          2: v = 16'($urandom_range(1, 2000));
          default: v = 16'($urandom_range(2, 24));
        endcase
        cfg_write(tfd_pkg::REG_COUNT_LIMIT, v);
      end
      settings_used++;

      // Some phases run back to back; one holds the result side off for a long stretch.
      bursty     = (phase % 4 != 3);
      burst_left = 0;
      if (phase == 2) begin
        bursty  = 1'b0;
        rx_hold = 150;
      end

      n = $urandom_range(20, 60);
      for (k = 0; k < n; k++) begin
        if (trend_left == 0) begin
          rising_trend = !rising_trend;
          trend_left   = $urandom_range(2, 30);
        end
        trend_left--;
        if (bursty && burst_left == 0) begin
          idle_sender($urandom_range(1, 8));
          burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0) burst_left--;

        exc = ($urandom_range(0, 99) < 85) ? rising_trend : !rising_trend;
        smp = SAMPLE_W'($urandom);
        r   = $urandom_range(0, 99);
        if (r < 4) begin
          act = tfd_pkg::ACT_CLEAR;
        end else if (r < 7) begin
          act = tfd_pkg::ACT_NONE;
        end else if (r < 50) begin
          act = tfd_pkg::ACT_BOOL;
        end else begin
          act = tfd_pkg::ACT_SAMPLE;
          case ($urandom_range(0, 9))
            0: ;
            1: smp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: begin
              // Aim just beyond (or exactly at) the level that moves the counter.
              delta = $urandom_range(0, 300);
              if (exc)
                smp = shift_level(sb.trip_level, sb.ctrl.under_trips ? -delta : delta);
              else
                smp = shift_level(sb.recover_level, sb.ctrl.under_trips ? delta : -delta);
            end
          endcase
        end
        drive_item(act, exc, smp);
      end
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.expected_q.size()));

    $display("Summary: %0d items over %0d settings (%0d register writes), %0d results checked.",
             items_sent, settings_used, cfg_writes, sb.checked);
    $display("Summary: the counter hit its limit %0d times and zero %0d times.",
             sb.saturations, sb.zero_hits);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
